// ===== sv/hsl_to_rgb444_assert.svh =====
// ----------------------------------------------------------------------------
// hsl_to_rgb444 assertion macros
// Concurrent checks on the rising edge of clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB444_ASSERT_SVH
`define HSL_TO_RGB444_ASSERT_SVH

// Check that cond implies expr in the same cycle
`define HSL444_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("hsl_to_rgb444 check failed");

// Check that cond implies expr in the next cycle
`define HSL444_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("hsl_to_rgb444 check failed");

`endif

// ===== sv/hsl444_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsl444_pkg
// Shared constants and the hue-to-ramp-factor function of the HSL converter.
// ----------------------------------------------------------------------------
package hsl444_pkg;

    // Default fraction bits of saturation and lightness
    localparam int FRAC_BITS_DEF = 8;

    // Hue is a fraction of a turn on 1536 steps
    localparam int HUE_W = 11;
    localparam logic [HUE_W-1:0] HUE_STEPS      = 11'd1536;
    localparam logic [HUE_W-1:0] HUE_THIRD      = 11'd512;
    localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 11'd1024;

    // Breakpoints of the piecewise channel rule
    localparam logic [HUE_W-1:0] RISE_END   = 11'd256;
    localparam logic [HUE_W-1:0] FALL_START = 11'd768;
    localparam logic [HUE_W-1:0] FALL_END   = 11'd1024;

    // Ramp factor runs 0..256
    localparam int FACTOR_W = 9;
    localparam logic [FACTOR_W-1:0] FACTOR_FULL = 9'd256;

    // Channel is 8 bits, high nibble kept
    localparam int CHAN_W   = 8;
    localparam int NIBBLE_W = 4;

    // Weight of the (q - p) term for one hue argument
    function automatic logic [FACTOR_W-1:0] hue_factor(input logic [HUE_W-1:0] t);
        logic [HUE_W-1:0] fall;
        begin
            fall = FALL_END - t;
            if (t < RISE_END)
                hue_factor = t[FACTOR_W-1:0];
            else if (t < FALL_START)
                hue_factor = FACTOR_FULL;
            else if (t < FALL_END)
                hue_factor = fall[FACTOR_W-1:0];
            else
                hue_factor = '0;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/hsl444_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsl444_lane
// One color channel: ramp factor, channel value, scale by 255, high nibble.
// ----------------------------------------------------------------------------
module hsl444_lane
    import hsl444_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      advance,
    input  wire logic [HUE_W-1:0]          hue_arg,
    input  wire logic [2*FRAC_BITS:0]      p_val,
    input  wire logic [2*FRAC_BITS:0]      d_val,
    output logic      [NIBBLE_W-1:0]       nibble
);

    localparam int PW = 2 * FRAC_BITS + 1;
    localparam int VW = PW + 8;
    localparam int MW = VW + 8;
    localparam int CH_LSB = 2 * FRAC_BITS + 8;

    logic [FACTOR_W-1:0] factor_reg;
    logic [VW-1:0]       value_reg;
    logic [VW-1:0]       value_next;
    logic [MW-1:0]       scaled;
    logic [NIBBLE_W-1:0] nibble_reg;

    // Channel value at scale 2^(2F+8): 256*p + (q-p)*factor
    assign value_next = {p_val, 8'd0} + (VW'(d_val) * VW'(factor_reg));

    // Scale by 255 as shift and subtract
    assign scaled = {value_reg, 8'd0} - MW'(value_reg);

    // Advance the three lane stages together
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            factor_reg <= hue_factor(hue_arg);
            value_reg  <= value_next;
            nibble_reg <= scaled[CH_LSB+CHAN_W-1 -: NIBBLE_W];
        end
    end

    assign nibble = nibble_reg;

endmodule
`default_nettype wire

// ===== sv/hsl_to_rgb444.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_to_rgb444
// HSL to RGB444 color converter, four-stage pipe, one beat per unstalled cycle.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  hsl      in         hsl_valid/hsl_stall   hue, saturation, lightness
//  rgb      out        rgb_valid/rgb_stall   red/green/blue_nibble, packed_colour
//
//  One beat enters per cycle while hsl_stall is low; it leaves from stage 4.
//  Stages: clamp and wrap with l*s product, q/p forming, one (q-p)*factor
//  multiplier per channel, scale by 255 into the output register.
//  rgb_stall with a waiting beat freezes every stage and raises hsl_stall.
//  Reset clears the valid bits only; no item is in flight after reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb444
    import hsl444_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  hsl_valid,
    output logic                       hsl_stall,
    input  wire logic [HUE_W-1:0]      hue,
    input  wire logic [FRAC_BITS:0]    saturation,
    input  wire logic [FRAC_BITS:0]    lightness,
    output logic                       rgb_valid,
    input  wire logic                  rgb_stall,
    output logic [NIBBLE_W-1:0]        red_nibble,
    output logic [NIBBLE_W-1:0]        green_nibble,
    output logic [NIBBLE_W-1:0]        blue_nibble,
    output logic [3*NIBBLE_W-1:0]      packed_colour
);

    localparam int SW = FRAC_BITS + 1;
    localparam int PW = 2 * FRAC_BITS + 1;
    localparam int XW = 2 * FRAC_BITS + 2;
    localparam logic [SW-1:0] ONE_FX  = SW'(1) << FRAC_BITS;
    localparam logic [SW-1:0] HALF_FX = SW'(1) << (FRAC_BITS - 1);
    localparam logic [PW:0]   Q_MAX   = (PW + 1)'(1) << (2 * FRAC_BITS);

    logic advance;

    // Valid bits of the four stages
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1 payload
    logic [SW-1:0]    sat_c, light_c;
    logic [HUE_W-1:0] hue_w, hue_r, hue_b;
    logic [2*SW-1:0]  ls_full;
    logic [SW-1:0]    s1_reg, l1_reg;
    logic [PW-1:0]    ls1_reg;
    logic             low1_reg;
    logic [HUE_W-1:0] tr1_reg, tg1_reg, tb1_reg;

    // Stage 2 payload
    logic [XW-1:0] l_x, s_x, ls_x, q_x, p_x, d_x;
    logic [PW-1:0] p2_reg, d2_reg;

    // Freeze the whole pipe while a finished beat waits
    assign advance   = !(v4_reg && rgb_stall);
    assign hsl_stall = !advance;

    // Clamp saturation and lightness to 1.0
    assign sat_c   = (saturation > ONE_FX) ? ONE_FX : saturation;
    assign light_c = (lightness  > ONE_FX) ? ONE_FX : lightness;
    assign ls_full = (2 * SW)'(light_c) * (2 * SW)'(sat_c);

    // Wrap hue, then form the red and blue arguments a third apart
    assign hue_w = (hue >= HUE_STEPS) ? hue - HUE_STEPS : hue;
    assign hue_r = (hue_w >= HUE_TWO_THIRDS) ? hue_w - HUE_TWO_THIRDS : hue_w + HUE_THIRD;
    assign hue_b = (hue_w >= HUE_THIRD) ? hue_w - HUE_THIRD : hue_w + HUE_TWO_THIRDS;

    // Form q, p and q - p at scale 2^(2F)
    assign l_x  = XW'(l1_reg) << FRAC_BITS;
    assign s_x  = XW'(s1_reg) << FRAC_BITS;
    assign ls_x = XW'(ls1_reg);
    assign q_x  = low1_reg ? (l_x + ls_x) : (l_x + s_x - ls_x);
    assign p_x  = (XW'(l1_reg) << (FRAC_BITS + 1)) - q_x;
    assign d_x  = q_x - p_x;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= hsl_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance stage 1 and stage 2 payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg   <= sat_c;
            l1_reg   <= light_c;
            ls1_reg  <= ls_full[PW-1:0];
            low1_reg <= (light_c < HALF_FX);
            tr1_reg  <= hue_r;
            tg1_reg  <= hue_w;
            tb1_reg  <= hue_b;
            p2_reg   <= p_x[PW-1:0];
            d2_reg   <= d_x[PW-1:0];
        end
    end

    // Channel lanes, stages 2 to 4
    hsl444_lane #(.FRAC_BITS(FRAC_BITS)) u_red
    (
        .clk     (clk),
        .advance (advance),
        .hue_arg (tr1_reg),
        .p_val   (p2_reg),
        .d_val   (d2_reg),
        .nibble  (red_nibble)
    );

    hsl444_lane #(.FRAC_BITS(FRAC_BITS)) u_green
    (
        .clk     (clk),
        .advance (advance),
        .hue_arg (tg1_reg),
        .p_val   (p2_reg),
        .d_val   (d2_reg),
        .nibble  (green_nibble)
    );

    hsl444_lane #(.FRAC_BITS(FRAC_BITS)) u_blue
    (
        .clk     (clk),
        .advance (advance),
        .hue_arg (tb1_reg),
        .p_val   (p2_reg),
        .d_val   (d2_reg),
        .nibble  (blue_nibble)
    );

    assign rgb_valid     = v4_reg;
    assign packed_colour = {red_nibble, green_nibble, blue_nibble};

`include "hsl_to_rgb444_assert.svh"

    // A gray input leaves no (q - p) term
    `HSL444_ASSERT_NEXT(a_gray_no_spread, v1_reg && advance && (s1_reg == '0), d2_reg == '0)
    // q never exceeds 1.0 squared
    `HSL444_ASSERT_NOW(a_q_bound, v2_reg, ({1'b0, p2_reg} + {1'b0, d2_reg}) <= Q_MAX)
    // Input is held off only behind a waiting output beat
    `HSL444_ASSERT_NOW(a_stall_cause, hsl_stall, rgb_valid)
    // A frozen stage keeps its beat
    `HSL444_ASSERT_NEXT(a_hold_stage2, v2_reg && hsl_stall, v2_reg && $stable(d2_reg))

endmodule
`default_nettype wire
